### rtl/rptt_pkg.sv
// Shared constants and types for the relative position / transit time core.
package rptt_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int FIELD_WIDTH   = 32;
   localparam int DP_WIDTH      = 64;   // CORDIC x/y datapath
   localparam int ZW            = 34;   // angle accumulator, 2^32 per turn
   localparam int SLOW_WIDTH    = 26;
   localparam int RANGE_WIDTH   = 33;
   localparam int ANG_OUT_WIDTH = 16;
   localparam int ARR_WIDTH     = 40;
   localparam int REQ_DATA_WIDTH = 7 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = 112;

   localparam logic [SLOW_WIDTH-1:0]  SLOWNESS_RESET = 26'd11184811;
   localparam logic [31:0]            INV_GAIN_Q32   = 32'h9B74EDA8;
   localparam logic [RANGE_WIDTH-1:0] RANGE_MAX      = '1;
   localparam logic [ARR_WIDTH-1:0]   ARRIVAL_MAX    = '1;
   localparam logic signed [ZW-1:0]   HALF_TURN      = 34'sh0_8000_0000;
   localparam logic signed [ZW-1:0]   QUARTER_TURN   = 34'sh0_4000_0000;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

endpackage

### rtl/rptt_cordic_cell.sv
// One CORDIC vectoring micro-rotation cell with registered outputs.
module rptt_cordic_cell import rptt_pkg::*; #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [DP_WIDTH-1:0] x_in,
   input  logic signed [DP_WIDTH-1:0] y_in,
   input  logic signed [ZW-1:0]       z_in,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       out_valid,
   output logic signed [DP_WIDTH-1:0] x_out,
   output logic signed [DP_WIDTH-1:0] y_out,
   output logic signed [ZW-1:0]       z_out,
   output logic [SIDE_W-1:0]          side_out
);

   localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TAB[STAGE]);

   logic                       valid_ff;
   logic signed [DP_WIDTH-1:0] x_ff, x_in_c, y_ff, y_in_c;
   logic signed [ZW-1:0]       z_ff, z_in_c;
   logic [SIDE_W-1:0]          side_ff;
   logic signed [DP_WIDTH-1:0] xs, ys;

   always_comb begin
      xs = y_in >>> STAGE;
      ys = x_in >>> STAGE;
      if (y_in < 0) begin
         x_in_c = x_in - xs;
         y_in_c = y_in + ys;
         z_in_c = z_in - ATAN_I;
      end else begin
         x_in_c = x_in + xs;
         y_in_c = y_in - ys;
         z_in_c = z_in + ATAN_I;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in_c;
         y_ff    <= y_in_c;
         z_ff    <= z_in_c;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

endmodule

### rtl/rptt_unscale.sv
// CORDIC gain removal: floor(x * (1/K in Q32) / 2^32) over two stages.
module rptt_unscale import rptt_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [DP_WIDTH-1:0] x_in,
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       out_valid,
   output logic [DP_WIDTH-1:0]        u_out,
   output logic [SIDE_W-1:0]          side_out
);

   logic              v1_ff, v2_ff;
   logic [63:0]       ph_ff, pl_ff, u_ff;
   logic [SIDE_W-1:0] s1_ff, s2_ff;
   logic [63:0]       a;

   // negative magnitude cannot occur in practice; clamp to zero
   assign a = (x_in < 0) ? 64'd0 : 64'(x_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= 64'(a[63:32]) * 64'(INV_GAIN_Q32);
         pl_ff <= 64'(a[31:0]) * 64'(INV_GAIN_Q32);
         s1_ff <= side_in;
         u_ff  <= ph_ff + (pl_ff >> 32);
         s2_ff <= s1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign u_out     = u_ff;
   assign side_out  = s2_ff;

endmodule

### rtl/relative_position_transit_time_core.sv
// Relative position and acoustic transit time: top level.
//
// req_ channel: one transaction carries sender and receiver positions
// (signed mm) and a start time in us. rsp_ channel: one transaction per
// request with range (mm), bearing and elevation (binary angles, pi at
// 2^(ANGLE_WIDTH-1)) and saturated arrival time in us.
// csr_we/csr_wdata write the sound slowness (us per mm, Q24) at any edge.
//
// Datapath: input subtract stage, CORDIC_STAGES cells for the bearing pass,
// two-stage gain removal, CORDIC_STAGES cells for the elevation pass,
// two-stage gain removal, range round stage, slowness multiply, output
// register. One transaction per cycle is sustained, fixed by the cell
// chain, while the output is not blocked by a low rsp_tready.
//
// Reset empties the pipeline and loads the 1500 m/s slowness. When
// rsp_tready is low, the result holds in the output register and the
// pipeline still advances until a valid item reaches the last stage, then
// the whole chain stalls and req_tready drops.
module relative_position_transit_time_core import rptt_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // src_x, src_y, src_z, dst_x, dst_y, dst_z, start_us (32 b each)
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // range_mm[32:0], bearing_angle[48:33], elevation_angle[64:49],
   // arrival_us[104:65], zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_we,
   input  logic [SLOW_WIDTH-1:0]     csr_wdata
);

   localparam int G   = 58 - COORD_WIDTH;
   localparam int N   = CORDIC_STAGES;
   localparam int S1W = DP_WIDTH + FIELD_WIDTH;
   localparam int U1W = S1W + ANG_OUT_WIDTH;
   localparam int S2W = FIELD_WIDTH + ANG_OUT_WIDTH;
   localparam int U2W = S2W + ANG_OUT_WIDTH;
   localparam int PW  = RANGE_WIDTH + SLOW_WIDTH;

   logic adv, last_v;
   logic [SLOW_WIDTH-1:0] slow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_ff <= SLOWNESS_RESET;
      end else if (csr_we) begin
         slow_ff <= csr_wdata;
      end
   end

   // ---------------- input stage ----------------
   logic signed [DP_WIDTH-1:0] d [3];
   logic signed [DP_WIDTH-1:0] x0_in, y0_in, z0d_ff, x0_ff, y0_ff;
   logic signed [ZW-1:0]       base_in, base_ff;
   logic [FIELD_WIDTH-1:0]     st0_ff;
   logic                       v0_ff;

   for (genvar k = 0; k < 3; k++) begin : g_diff
      logic signed [COORD_WIDTH-1:0] ca, cb;
      logic signed [DP_WIDTH-1:0]    ea, eb;
      assign ca   = COORD_WIDTH'(req_tdata[k*FIELD_WIDTH +: FIELD_WIDTH]);
      assign cb   = COORD_WIDTH'(req_tdata[(k+3)*FIELD_WIDTH +: FIELD_WIDTH]);
      assign ea   = DP_WIDTH'(ca);
      assign eb   = DP_WIDTH'(cb);
      assign d[k] = (ea - eb) <<< G;
   end

   // left half plane: turn by pi first
   always_comb begin
      if (d[0] < 0) begin
         x0_in   = -d[0];
         y0_in   = -d[1];
         base_in = HALF_TURN;
      end else begin
         x0_in   = d[0];
         y0_in   = d[1];
         base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff   <= x0_in;
         y0_ff   <= y0_in;
         z0d_ff  <= d[2];
         base_ff <= base_in;
         st0_ff  <= req_tdata[6*FIELD_WIDTH +: FIELD_WIDTH];
      end
   end

   // ---------------- bearing pass ----------------
   logic                       c1_v [N+1];
   logic signed [DP_WIDTH-1:0] c1_x [N+1];
   logic signed [DP_WIDTH-1:0] c1_y [N+1];
   logic signed [ZW-1:0]       c1_z [N+1];
   logic [S1W-1:0]             c1_s [N+1];

   assign c1_v[0] = v0_ff;
   assign c1_x[0] = x0_ff;
   assign c1_y[0] = y0_ff;
   assign c1_z[0] = base_ff;
   assign c1_s[0] = {z0d_ff, st0_ff};

   for (genvar i = 0; i < N; i++) begin : g_pass1
      rptt_cordic_cell #(.STAGE(i), .SIDE_W(S1W)) u_cell (
         .clock, .reset, .en(adv),
         .in_valid(c1_v[i]), .x_in(c1_x[i]), .y_in(c1_y[i]), .z_in(c1_z[i]),
         .side_in(c1_s[i]),
         .out_valid(c1_v[i+1]), .x_out(c1_x[i+1]), .y_out(c1_y[i+1]),
         .z_out(c1_z[i+1]), .side_out(c1_s[i+1])
      );
   end

   logic [31:0] bsum;
   logic signed [ANGLE_WIDTH-1:0] bt;
   logic signed [39:0] bext;
   assign bsum = c1_z[N][31:0] + (32'd1 << (31 - ANGLE_WIDTH));
   assign bt   = bsum[31 -: ANGLE_WIDTH];
   assign bext = 40'(bt);

   logic           u1_v;
   logic [63:0]    u1_u;
   logic [U1W-1:0] u1_s;

   rptt_unscale #(.SIDE_W(U1W)) u_unscale1 (
      .clock, .reset, .en(adv),
      .in_valid(c1_v[N]), .x_in(c1_x[N]), .side_in({c1_s[N], bext[15:0]}),
      .out_valid(u1_v), .u_out(u1_u), .side_out(u1_s)
   );

   // ---------------- elevation pass ----------------
   logic                       c2_v [N+1];
   logic signed [DP_WIDTH-1:0] c2_x [N+1];
   logic signed [DP_WIDTH-1:0] c2_y [N+1];
   logic signed [ZW-1:0]       c2_z [N+1];
   logic [S2W-1:0]             c2_s [N+1];

   assign c2_v[0] = u1_v;
   assign c2_x[0] = DP_WIDTH'(u1_u);
   assign c2_y[0] = u1_s[U1W-1 -: DP_WIDTH];
   assign c2_z[0] = '0;
   assign c2_s[0] = u1_s[S2W-1:0];

   for (genvar i = 0; i < N; i++) begin : g_pass2
      rptt_cordic_cell #(.STAGE(i), .SIDE_W(S2W)) u_cell (
         .clock, .reset, .en(adv),
         .in_valid(c2_v[i]), .x_in(c2_x[i]), .y_in(c2_y[i]), .z_in(c2_z[i]),
         .side_in(c2_s[i]),
         .out_valid(c2_v[i+1]), .x_out(c2_x[i+1]), .y_out(c2_y[i+1]),
         .z_out(c2_z[i+1]), .side_out(c2_s[i+1])
      );
   end

   logic signed [ZW-1:0] ez;
   logic [31:0] esum;
   logic signed [ANGLE_WIDTH-1:0] et;
   logic signed [39:0] eext;
   always_comb begin
      ez = c2_z[N];
      if (ez > QUARTER_TURN) ez = QUARTER_TURN;
      if (ez < -QUARTER_TURN) ez = -QUARTER_TURN;
   end
   assign esum = ez[31:0] + (32'd1 << (31 - ANGLE_WIDTH));
   assign et   = esum[31 -: ANGLE_WIDTH];
   assign eext = 40'(et);

   logic           u2_v;
   logic [63:0]    u2_u;
   logic [U2W-1:0] u2_s;

   rptt_unscale #(.SIDE_W(U2W)) u_unscale2 (
      .clock, .reset, .en(adv),
      .in_valid(c2_v[N]), .x_in(c2_x[N]), .side_in({c2_s[N], eext[15:0]}),
      .out_valid(u2_v), .u_out(u2_u), .side_out(u2_s)
   );

   // ---------------- range, travel, output ----------------
   logic [64:0] rsum, rq;
   logic [RANGE_WIDTH-1:0] rng_in, rng_ff, rngp_ff;
   logic [U2W-1:0] r_s_ff, p_s_ff;
   logic [PW-1:0]  prod_ff;
   logic           r_v_ff, p_v_ff;

   assign rsum   = 65'(u2_u) + (65'd1 << (G - 1));
   assign rq     = rsum >> G;
   assign rng_in = (rq > 65'(RANGE_MAX)) ? RANGE_MAX : rq[RANGE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
      end else if (adv) begin
         r_v_ff <= u2_v;
         p_v_ff <= r_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rng_ff  <= rng_in;
         r_s_ff  <= u2_s;
         prod_ff <= PW'(rng_ff) * PW'(slow_ff);
         rngp_ff <= rng_ff;
         p_s_ff  <= r_s_ff;
      end
   end

   logic [PW-1:0]      tsum;
   logic [PW-25:0]     travel;
   logic [ARR_WIDTH:0] asum;
   logic [ARR_WIDTH-1:0] arr_in;
   assign tsum   = prod_ff + (PW'(1) << 23);
   assign travel = tsum[PW-1:24];
   assign asum   = (ARR_WIDTH+1)'(p_s_ff[U2W-1 -: FIELD_WIDTH]) + (ARR_WIDTH+1)'(travel);
   assign arr_in = (asum > (ARR_WIDTH+1)'(ARRIVAL_MAX)) ? ARRIVAL_MAX : asum[ARR_WIDTH-1:0];

   assign last_v = p_v_ff;

   logic out_v_ff, out_v_in;
   logic [RSP_DATA_WIDTH-1:0] out_d_ff;

   assign adv      = !last_v || !out_v_ff || rsp_tready;
   assign out_v_in = (adv && last_v) || (out_v_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_v) begin
         out_d_ff <= {7'd0, arr_in, p_s_ff[ANG_OUT_WIDTH-1:0],
                      p_s_ff[2*ANG_OUT_WIDTH-1:ANG_OUT_WIDTH], rngp_ff};
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && last_v))
      else $error("input stalled without a blocked output");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (last_v && !adv) |=> last_v)
      else $error("last stage item lost during stall");

   a_elev_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ANGLE_WIDTH != 16 ||
         ($signed(rsp_tdata[64:49]) <= 16384 && $signed(rsp_tdata[64:49]) >= -16384)))
      else $error("elevation beyond quarter turn");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### test/tb_relative_position_transit_time_core.sv
// Testbench for relative_position_transit_time_core: directed and random positions.
`timescale 1ns / 100ps

module tb_relative_position_transit_time_core;
   import rptt_pkg::*;

   localparam int          LATENCY     = 2 * CORDIC_STAGES_DEF + 8;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int unsigned SLOW_MAX    = 26'h3FF_FFFF;

   typedef struct packed {
      logic [31:0]        start_us;
      logic signed [31:0] dst_z;
      logic signed [31:0] dst_y;
      logic signed [31:0] dst_x;
      logic signed [31:0] src_z;
      logic signed [31:0] src_y;
      logic signed [31:0] src_x;
   } position_pair_type;

   typedef struct packed {
      logic [ARR_WIDTH-1:0]     arrival_us;
      logic [ANG_OUT_WIDTH-1:0] elevation_angle;
      logic [ANG_OUT_WIDTH-1:0] bearing_angle;
      logic [RANGE_WIDTH-1:0]   range_mm;
   } transit_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_we = 1'b0;
   logic [SLOW_WIDTH-1:0]     csr_wdata = '0;

   transit_type           expected_transits[$];
   logic [SLOW_WIDTH-1:0] slowness = SLOWNESS_RESET;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    rsp_hold_cycles = 0;
   int                    mismatches = 0;
   int                    cycles = 0;

   relative_position_transit_time_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // src_x, src_y, src_z, dst_x, dst_y, dst_z, start_us
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // range_mm, bearing_angle, elevation_angle, arrival_us, pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint cordic_vector(inout longint x, inout longint y);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         xs = y >>> i;
         ys = x >>> i;
         if (y < 0) begin
            x = x - xs;
            y = y + ys;
            z = z - longint'(ATAN_TAB[i]);
         end else begin
            x = x + xs;
            y = y - ys;
            z = z + longint'(ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned remove_gain(longint v);
      longint unsigned a;
      longint unsigned c;
      a = (v < 0) ? 64'd0 : longint'(v);
      c = {32'd0, INV_GAIN_Q32};
      return (a >> 32) * c + (((a & 64'hFFFF_FFFF) * c) >> 32);
   endfunction

   function automatic logic [15:0] binary_angle(longint z);
      logic [31:0] a;
      a = z[31:0] + 32'h0000_8000;
      return a[31:16];
   endfunction

   function automatic transit_type predict_transit(position_pair_type p,
                                                   logic [SLOW_WIDTH-1:0] slow);
      transit_type     t;
      longint          dx;
      longint          dy;
      longint          dz;
      longint          hx;
      longint          bear;
      longint          elev;
      longint unsigned rng;
      longint unsigned travel;
      longint unsigned arrival;
      dx = (longint'(p.src_x) - longint'(p.dst_x)) * 64'sd67108864;
      dy = (longint'(p.src_y) - longint'(p.dst_y)) * 64'sd67108864;
      dz = (longint'(p.src_z) - longint'(p.dst_z)) * 64'sd67108864;
      bear = 0;
      // left half plane: rotate by pi first
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
         bear = 64'sh8000_0000;
      end
      bear = bear + cordic_vector(dx, dy);
      hx = longint'(remove_gain(dx));
      elev = cordic_vector(hx, dz);
      if (elev > 64'sh4000_0000) elev = 64'sh4000_0000;
      if (elev < -64'sh4000_0000) elev = -64'sh4000_0000;
      rng = (remove_gain(hx) + (64'd1 << 25)) >> 26;
      if (rng > 64'h1_FFFF_FFFF) rng = 64'h1_FFFF_FFFF;
      travel = (rng * {38'd0, slow} + (64'd1 << 23)) >> 24;
      arrival = {32'd0, p.start_us} + travel;
      if (arrival > 64'hFF_FFFF_FFFF) arrival = 64'hFF_FFFF_FFFF;
      t.range_mm        = rng[RANGE_WIDTH-1:0];
      t.bearing_angle   = binary_angle(bear);
      t.elevation_angle = binary_angle(elev);
      t.arrival_us      = arrival[ARR_WIDTH-1:0];
      return t;
   endfunction

   // ---------------- driver ----------------
   task automatic send_position(position_pair_type p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= p;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_transits.push_back(predict_transit(p, slowness));
   endtask

   task automatic drain_pipeline();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (expected_transits.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_slowness(logic [SLOW_WIDTH-1:0] value);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      slowness = value;
   endtask

   function automatic position_pair_type random_pair();
      position_pair_type p;
      int                span;
      p.start_us = $urandom;
      p.src_x = $urandom;
      p.src_y = $urandom;
      p.src_z = $urandom;
      case ($urandom_range(3))
         0: begin
            p.dst_x = $urandom;
            p.dst_y = $urandom;
            p.dst_z = $urandom;
         end
         default: begin
            // receiver near the sender: fine angles and short ranges
            span = (1 << $urandom_range(20)) - 1;
            p.dst_x = p.src_x + $urandom_range(2 * span) - span;
            p.dst_y = p.src_y + $urandom_range(2 * span) - span;
            p.dst_z = p.src_z + $urandom_range(2 * span) - span;
         end
      endcase
      return p;
   endfunction

   function automatic position_pair_type offset_pair(int dx, int dy, int dz,
                                                     logic [31:0] start);
      position_pair_type p;
      p.src_x = 1000 + dx;
      p.src_y = -2000 + dy;
      p.src_z = 30 + dz;
      p.dst_x = 1000;
      p.dst_y = -2000;
      p.dst_z = 30;
      p.start_us = start;
      return p;
   endfunction

   // ---------------- receiver and checker ----------------
   initial begin
      transit_type got;
      transit_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(transit_type)-1:0];
            if (expected_transits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: range %0d bearing %0d elev %0d arrival %0d",
                           got.range_mm, $signed(got.bearing_angle),
                           $signed(got.elevation_angle), got.arrival_us);
            end else begin
               want = expected_transits.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: range %0d/%0d bearing %0d/%0d elev %0d/%0d",
                               " arrival %0d/%0d (exp/act)"},
                              want.range_mm, got.range_mm,
                              $signed(want.bearing_angle), $signed(got.bearing_angle),
                              $signed(want.elevation_angle), $signed(got.elevation_angle),
                              want.arrival_us, got.arrival_us);
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      position_pair_type p;
      send_position(offset_pair(0, 0, 0, 32'd12345));          // zero vector
      send_position(offset_pair(5000, 0, 0, 32'd0));            // +x
      send_position(offset_pair(-5000, 0, 0, 32'd1));           // bearing of pi
      send_position(offset_pair(0, 7000, 0, 32'd2));            // +y
      send_position(offset_pair(0, -7000, 0, 32'd3));           // -y
      send_position(offset_pair(-300, 400, 0, 32'd4));          // left half, upper
      send_position(offset_pair(-300, -400, 0, 32'd5));         // left half, lower
      send_position(offset_pair(0, 0, 9000, 32'hFFFF_FFFF));    // straight up
      send_position(offset_pair(0, 0, -9000, 32'd6));           // straight down
      send_position(offset_pair(1, 1, 1, 32'd7));
      send_position(offset_pair(-1, -1, -1, 32'd8));
      p.src_x = 32'h7FFF_FFFF; p.src_y = 32'h7FFF_FFFF; p.src_z = 32'h7FFF_FFFF;
      p.dst_x = 32'h8000_0000; p.dst_y = 32'h8000_0000; p.dst_z = 32'h8000_0000;
      p.start_us = 32'hFFFF_FFFF;
      send_position(p);                                          // largest range
      p.src_x = 32'h8000_0000; p.src_y = 32'h7FFF_FFFF; p.src_z = 32'h8000_0000;
      p.dst_x = 32'h7FFF_FFFF; p.dst_y = 32'h8000_0000; p.dst_z = 32'h7FFF_FFFF;
      p.start_us = 32'd0;
      send_position(p);
      p = '1;
      send_position(p);
      p = '0;
      p.src_z = 32'h7FFF_FFFF;
      send_position(p);
      p.src_z = 32'h8000_0000;
      send_position(p);
      for (int i = 0; i < 4; i++) send_position(random_pair());
   endtask

   task automatic test_random_phase(int items, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < items; i++) send_position(random_pair());
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 150; i++) send_position(random_pair());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(250, 0, 0);
      write_slowness(SLOW_MAX);
      test_directed();
      test_random_phase(250, 85, 0);
      write_slowness(26'd1);
      test_random_phase(250, 0, 85);
      write_slowness($urandom_range(SLOW_MAX, 1));
      test_random_phase(250, 20, 20);
      test_backpressure();
      write_slowness(SLOWNESS_RESET);
      test_random_phase(150, 0, 0);
      drain_pipeline();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
